[src/srt_pkg.sv]
`default_nettype none
package srt_pkg;

    localparam int MAX_SIDE    = 8;
    localparam int SIDE_W      = 4;
    localparam int POS_W       = 3;
    localparam int CNT_W       = 7;
    localparam int SYM_W       = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SIDE_W-1:0] RESET_SIDE = SIDE_W'(2);
    localparam logic [SIDE_W:0]   MIN_SIDE   = (SIDE_W+1)'(2);
    localparam logic [SIDE_W:0]   TOP_SIDE   = (SIDE_W+1)'((MAX_SIDE / 2) * 2);
    localparam logic [SYM_W-1:0]  PAD_SYMBOL = SYM_W'(32);
    localparam logic [POS_W-1:0]  RUN_GROWTH = POS_W'(2);

    typedef enum logic [2:0] {
        PH_START,
        PH_LEFT,
        PH_DOWN,
        PH_RIGHT,
        PH_UP,
        PH_EXTRA
    } phase_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             is_final;
        logic             drop;
    } cmd_t;

    typedef struct packed {
        logic             fire;
        logic [POS_W-1:0] start;
    } restart_t;

    typedef struct packed {
        logic [CNT_W-1:0] cells;
        logic             padding;
    } back_status_t;

    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] side);
        logic [SIDE_W:0] s;
        s = {1'b0, side} + {{SIDE_W{1'b0}}, side[0]};
        if (s < MIN_SIDE) s = MIN_SIDE;
        if (s > TOP_SIDE) s = TOP_SIDE;
        return s[SIDE_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] area_of(input logic [SIDE_W-1:0] e);
        logic [2*SIDE_W-1:0] p;
        p = {{SIDE_W{1'b0}}, e} * {{SIDE_W{1'b0}}, e};
        return p[CNT_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] start_cell(input logic [SIDE_W-1:0] e);
        logic [SIDE_W-1:0] h;
        h = (e >> 1) - SIDE_W'(1);
        return h[POS_W-1:0];
    endfunction

endpackage
`default_nettype wire

[src/spiral_route_transposer.sv]
// Path: each byte is registered in the command queue, and its result beat then in the
//   output register, where it waits for m_ready.
// Throughput: one byte in and one result beat out per cycle while m_ready is high;
//   a final byte keeps the spiral sequencer for one padding beat per remaining cell,
//   while the two-entry command queue goes on taking bytes until it fills.
// Reset: synchronous, active low; side returns to 2 and the square restarts
//   empty. A side write restarts the square the same way. No clearing pass.
`default_nettype none
module spiral_route_transposer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [srt_pkg::SIDE_W-1:0]    cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [srt_pkg::SYM_W-1:0]     s_symbol,
    input  wire logic                          s_is_final,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [srt_pkg::POS_W-1:0]          m_row,
    output logic [srt_pkg::POS_W-1:0]          m_col,
    output logic [srt_pkg::SYM_W-1:0]          m_out_symbol,
    output logic                               m_dropped,
    output logic                               m_end_of_square
);

    logic [srt_pkg::SIDE_W-1:0] side_reg;
    logic [srt_pkg::CNT_W-1:0]  area;
    srt_pkg::restart_t          restart;
    srt_pkg::cmd_t              push_cmd;
    srt_pkg::cmd_t              pop_cmd;
    srt_pkg::back_status_t      back_status;
    logic                       push;
    logic                       pop;
    logic                       q_full;
    logic                       q_empty;
    logic [srt_pkg::CNT_W-1:0]  front_count;

    assign cfg_ready = 1'b1;
    assign area      = srt_pkg::area_of(srt_pkg::eff_side(side_reg));

    always_comb begin
        restart.fire  = cfg_valid && cfg_ready;
        restart.start = srt_pkg::start_cell(srt_pkg::eff_side(cfg_data));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= srt_pkg::RESET_SIDE;
        end else if (restart.fire) begin
            side_reg <= cfg_data;
        end
    end

    srt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_symbol   (s_symbol),
        .s_is_final (s_is_final),
        .area       (area),
        .restart    (restart),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd),
        .count      (front_count)
    );

    srt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    srt_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (!q_empty),
        .cmd             (pop_cmd),
        .pop             (pop),
        .area            (area),
        .restart         (restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_row           (m_row),
        .m_col           (m_col),
        .m_out_symbol    (m_out_symbol),
        .m_dropped       (m_dropped),
        .m_end_of_square (m_end_of_square),
        .status          (back_status)
    );

    // sequencer never gets ahead of the classifier
    a_count_order: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.cells <= front_count)
        else $error("spiral sequencer ahead of front count");

    // padding runs only while its final byte is still queued
    a_pad_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.padding |-> !q_empty)
        else $error("padding without a queued final byte");

    a_drop_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_dropped) |-> (m_row == '0 && m_col == '0 && !m_end_of_square))
        else $error("dropped beat carries a cell");

endmodule
`default_nettype wire

[src/srt_front.sv]
`default_nettype none
module srt_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [srt_pkg::SYM_W-1:0]  s_symbol,
    input  wire logic                       s_is_final,
    input  wire logic [srt_pkg::CNT_W-1:0]  area,
    input  wire srt_pkg::restart_t          restart,
    input  wire logic                       q_full,
    output logic                            push,
    output srt_pkg::cmd_t                   push_cmd,
    output logic [srt_pkg::CNT_W-1:0]       count
);

    logic [srt_pkg::CNT_W-1:0] count_reg;
    logic [srt_pkg::CNT_W-1:0] count_next;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;
    assign count   = count_reg;

    always_comb begin
        push_cmd.symbol   = s_symbol;
        push_cmd.is_final = s_is_final;
        push_cmd.drop     = (count_reg >= area);
    end

    // a final byte commits the rest of the square to padding
    always_comb begin
        count_next = count_reg;
        if (restart.fire) begin
            count_next = '0;
        end else if (push && !push_cmd.drop) begin
            count_next = s_is_final ? area : count_reg + srt_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

[src/srt_queue.sv]
`default_nettype none
module srt_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire srt_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output srt_pkg::cmd_t      pop_cmd,
    output logic               empty
);

    localparam int PTR_W = $clog2(srt_pkg::QUEUE_DEPTH);
    localparam int FILL_W = $clog2(srt_pkg::QUEUE_DEPTH + 1);

    srt_pkg::cmd_t       entry_reg [srt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;

    assign full    = (fill_reg == FILL_W'(srt_pkg::QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        case ({push, pop})
            2'b10:   fill_next = fill_reg + FILL_W'(1);
            2'b01:   fill_next = fill_reg - FILL_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            fill_reg <= fill_next;
        end
    end

endmodule
`default_nettype wire

[src/srt_back.sv]
`default_nettype none
module srt_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cmd_valid,
    input  wire srt_pkg::cmd_t              cmd,
    output logic                            pop,
    input  wire logic [srt_pkg::CNT_W-1:0]  area,
    input  wire srt_pkg::restart_t          restart,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [srt_pkg::POS_W-1:0]       m_row,
    output logic [srt_pkg::POS_W-1:0]       m_col,
    output logic [srt_pkg::SYM_W-1:0]       m_out_symbol,
    output logic                            m_dropped,
    output logic                            m_end_of_square,
    output srt_pkg::back_status_t           status
);

    localparam int POS_W = srt_pkg::POS_W;
    localparam int CNT_W = srt_pkg::CNT_W;

    srt_pkg::phase_t    run_phase_reg, run_phase_next;
    logic [POS_W-1:0]   run_progress_reg, run_progress_next;
    logic [POS_W-1:0]   run_length_reg, run_length_next;
    logic [POS_W-1:0]   cur_row_reg, cur_row_next;
    logic [POS_W-1:0]   cur_col_reg, cur_col_next;
    logic [CNT_W-1:0]   cells_reg;
    logic [CNT_W-1:0]   cells_inc;
    logic               padding_reg, padding_next;
    logic [POS_W:0]     side_run;

    logic               m_valid_reg;
    logic [POS_W-1:0]   m_row_reg;
    logic [POS_W-1:0]   m_col_reg;
    logic [srt_pkg::SYM_W-1:0] m_sym_reg;
    logic               m_dropped_reg;
    logic               m_end_reg;

    logic               fire;
    logic               advance;
    logic               end_hit;

    // one spiral step
    always_comb begin
        side_run          = {1'b0, run_length_reg} + (POS_W+1)'(1);
        run_phase_next    = run_phase_reg;
        run_progress_next = run_progress_reg;
        run_length_next   = run_length_reg;
        cur_row_next      = cur_row_reg;
        cur_col_next      = cur_col_reg;
        unique case (run_phase_reg)
            srt_pkg::PH_START: begin
                run_phase_next    = srt_pkg::PH_LEFT;
                run_progress_next = '0;
            end
            srt_pkg::PH_LEFT: begin
                if (run_progress_reg < run_length_reg) begin
                    run_progress_next = run_progress_reg + POS_W'(1);
                    cur_col_next      = cur_col_reg - POS_W'(1);
                end else begin
                    run_phase_next    = srt_pkg::PH_DOWN;
                    run_progress_next = POS_W'(1);
                    cur_row_next      = cur_row_reg + POS_W'(1);
                end
            end
            srt_pkg::PH_DOWN: begin
                if ({1'b0, run_progress_reg} < side_run) begin
                    run_progress_next = run_progress_reg + POS_W'(1);
                    cur_row_next      = cur_row_reg + POS_W'(1);
                end else begin
                    run_phase_next    = srt_pkg::PH_RIGHT;
                    run_progress_next = POS_W'(1);
                    cur_col_next      = cur_col_reg + POS_W'(1);
                end
            end
            srt_pkg::PH_RIGHT: begin
                if ({1'b0, run_progress_reg} < side_run) begin
                    run_progress_next = run_progress_reg + POS_W'(1);
                    cur_col_next      = cur_col_reg + POS_W'(1);
                end else begin
                    run_phase_next    = srt_pkg::PH_UP;
                    run_progress_next = POS_W'(1);
                    cur_row_next      = cur_row_reg - POS_W'(1);
                end
            end
            srt_pkg::PH_UP: begin
                if ({1'b0, run_progress_reg} < side_run) begin
                    run_progress_next = run_progress_reg + POS_W'(1);
                    cur_row_next      = cur_row_reg - POS_W'(1);
                end else begin
                    run_phase_next    = srt_pkg::PH_LEFT;
                    run_progress_next = '0;
                    run_length_next   = run_length_reg + srt_pkg::RUN_GROWTH;
                    cur_row_next      = cur_row_reg - POS_W'(1);
                end
            end
            default: begin
                run_phase_next    = srt_pkg::PH_LEFT;
                run_progress_next = '0;
                run_length_next   = run_length_reg + srt_pkg::RUN_GROWTH;
                cur_row_next      = cur_row_reg - POS_W'(1);
            end
        endcase
    end

    // beat control
    always_comb begin
        fire         = cmd_valid && (!m_valid_reg || m_ready);
        cells_inc    = cells_reg + CNT_W'(1);
        end_hit      = (cells_inc == area);
        pop          = 1'b0;
        advance      = 1'b0;
        padding_next = padding_reg;
        if (fire) begin
            if (cmd.drop) begin
                pop = 1'b1;
            end else begin
                advance = 1'b1;
                if (padding_reg) begin
                    if (end_hit) begin
                        padding_next = 1'b0;
                        pop          = 1'b1;
                    end
                end else if (cmd.is_final && !end_hit) begin
                    padding_next = 1'b1;
                end else begin
                    pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_phase_reg    <= srt_pkg::PH_START;
            run_progress_reg <= '0;
            run_length_reg   <= '0;
            cur_row_reg      <= srt_pkg::start_cell(srt_pkg::eff_side(srt_pkg::RESET_SIDE));
            cur_col_reg      <= srt_pkg::start_cell(srt_pkg::eff_side(srt_pkg::RESET_SIDE));
            cells_reg        <= '0;
            padding_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (restart.fire) begin
                run_phase_reg    <= srt_pkg::PH_START;
                run_progress_reg <= '0;
                run_length_reg   <= '0;
                cur_row_reg      <= restart.start;
                cur_col_reg      <= restart.start;
                cells_reg        <= '0;
                padding_reg      <= 1'b0;
            end else begin
                if (advance) begin
                    run_phase_reg    <= run_phase_next;
                    run_progress_reg <= run_progress_next;
                    run_length_reg   <= run_length_next;
                    cur_row_reg      <= cur_row_next;
                    cur_col_reg      <= cur_col_next;
                    cells_reg        <= cells_inc;
                end
                padding_reg <= padding_next;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            if (cmd.drop) begin
                m_row_reg     <= '0;
                m_col_reg     <= '0;
                m_sym_reg     <= cmd.symbol;
                m_dropped_reg <= 1'b1;
                m_end_reg     <= 1'b0;
            end else begin
                m_row_reg     <= cur_row_next;
                m_col_reg     <= cur_col_next;
                m_sym_reg     <= padding_reg ? srt_pkg::PAD_SYMBOL : cmd.symbol;
                m_dropped_reg <= 1'b0;
                m_end_reg     <= end_hit;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_row           = m_row_reg;
    assign m_col           = m_col_reg;
    assign m_out_symbol    = m_sym_reg;
    assign m_dropped       = m_dropped_reg;
    assign m_end_of_square = m_end_reg;

    always_comb begin
        status.cells   = cells_reg;
        status.padding = padding_reg;
    end

endmodule
`default_nettype wire
